// ===== src/bsa_pkg.sv =====
package bsa_pkg;

   localparam int MAP_BITS_DEFAULT = 8192;
   localparam int SIZE_W = 14;
   localparam int NW_W = SIZE_W - 5;
   localparam int WORD_BITS = 64;
   localparam int BIT_W = 6;
   localparam int GROUP_WORDS = 32;
   localparam int MAP_SIZE_RESET = 8192;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic REG_MAP_SIZE = 1'b0;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE = 1'b1;

   localparam logic [1:0] STATUS_OK = 2'd0;
   localparam logic [1:0] STATUS_FULL = 2'd1;
   localparam logic [1:0] STATUS_RANGE = 2'd2;

   typedef struct packed {
      logic              command;
      logic [SIZE_W-1:0] entry_index;
   } req_type;

   typedef struct packed {
      logic [SIZE_W-1:0] granted_index;
      logic [1:0]        status;
      logic [SIZE_W-1:0] free_count;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_FREE,
      ST_UPDATE
   } state_type;

   typedef struct packed {
      logic load;
      logic clear_step;
      logic scan_step;
      logic free_read;
      logic update;
      logic resp_full;
      logic resp_range;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic scan_hit;
      logic scan_full;
      logic range_bad;
   } ctrl_status_type;

   typedef struct packed {
      logic             found;
      logic [BIT_W-1:0] index;
   } pe_type;

   function automatic pe_type lowest_set(input logic [WORD_BITS-1:0] v);
      pe_type r;
      r.found = 1'b0;
      r.index = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (v[i]) begin
            r.found = 1'b1;
            r.index = BIT_W'(i);
         end
      end
      return r;
   endfunction

endpackage

// ===== src/bsa_ram.sv =====
module bsa_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 128
) (
   input  logic                                  clock,
   input  logic                                  we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                      wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                      rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== src/bsa_ctrl.sv =====
module bsa_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic                     req_command,
   input  bsa_pkg::ctrl_status_type stat,
   output bsa_pkg::ctrl_cmd_type    cmd,
   output logic                     busy
);
   import bsa_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (stat.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               state_in = (req_command == CMD_FREE) ? ST_FREE : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (stat.scan_full) begin
               state_in = ST_IDLE;
            end else if (stat.scan_hit) begin
               state_in = ST_UPDATE;
            end
         end
         ST_FREE: begin
            state_in = stat.range_bad ? ST_IDLE : ST_UPDATE;
         end
         ST_UPDATE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      cmd = '0;
      busy = 1'b1;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
         end
         ST_IDLE: begin
            busy = 1'b0;
            cmd.load = start;
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            cmd.resp_full = stat.scan_full;
         end
         ST_FREE: begin
            cmd.free_read = 1'b1;
            cmd.resp_range = stat.range_bad;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// ===== src/bsa_datapath.sv =====
module bsa_datapath #(
   parameter int MAP_BITS = bsa_pkg::MAP_BITS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  bsa_pkg::req_type            req_data,
   input  logic [bsa_pkg::SIZE_W-1:0]  map_size,
   input  bsa_pkg::ctrl_cmd_type       cmd,
   output bsa_pkg::ctrl_status_type    stat,
   output bsa_pkg::rsp_type            rsp_data,
   output logic                        rsp_strobe
);
   import bsa_pkg::*;

   localparam int WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
   localparam int AW = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int GROUPS = (WORDS + GROUP_WORDS - 1) / GROUP_WORDS;
   localparam int GW = (GROUPS > 1) ? $clog2(GROUPS) : 1;
   localparam int PAD_BITS = GROUPS * GROUP_WORDS;
   localparam int RESET_SIZE = (MAP_SIZE_RESET < MAP_BITS) ? MAP_SIZE_RESET : MAP_BITS;

   logic              cmd_ff, cmd_in;
   logic [SIZE_W-1:0] idx_ff, idx_in;
   logic [GW-1:0]     group_ff, group_in;
   logic [AW-1:0]     word_ff, word_in;
   logic [BIT_W-1:0]  bitpos_ff, bitpos_in;
   logic [SIZE_W-1:0] free_ff, free_in;
   logic [WORDS-1:0]  full_ff, full_in;
   logic [AW-1:0]     clr_ff, clr_in;
   rsp_type           rsp_ff, rsp_in;
   logic              strobe_ff, strobe_in;

   logic [SIZE_W-1:0]      size_s;
   logic [NW_W-1:0]        nw_s;
   logic [PAD_BITS-1:0]    full_pad;
   logic [GROUP_WORDS-1:0] grp_s;
   pe_type                 grp_pe;
   logic [31:0]            base_s;
   logic [31:0]            cand_s;
   logic [SIZE_W-1:0]      bit0_s;
   logic [AW-1:0]          free_word_s;
   logic [31:0]            lim_s;
   logic [WORD_BITS-1:0]   mask_s;
   pe_type                 alloc_pe;
   logic [WORD_BITS-1:0]   set_word;
   logic [WORD_BITS-1:0]   clr_word;

   logic                 ram_we;
   logic [AW-1:0]        ram_waddr;
   logic [WORD_BITS-1:0] ram_wdata;
   logic [AW-1:0]        ram_raddr;
   logic [WORD_BITS-1:0] ram_rdata;

   bsa_ram #(
      .WIDTH(WORD_BITS),
      .DEPTH(WORDS)
   ) u_map_ram (
      .clock(clock),
      .we(ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   always_comb begin
      size_s = (32'(map_size) < 32'(MAP_BITS)) ? map_size : SIZE_W'(MAP_BITS);
      nw_s = NW_W'((32'(size_s) + 32'(WORD_BITS - 1)) / WORD_BITS);
   end

   // lowest word of the current group that still has a clear bit
   always_comb begin
      full_pad = '1;
      full_pad[WORDS-1:0] = full_ff;
      grp_s = full_pad[32'(group_ff) * GROUP_WORDS +: GROUP_WORDS];
      grp_pe = lowest_set({{(WORD_BITS - GROUP_WORDS){1'b0}}, ~grp_s});
      base_s = 32'(group_ff) * GROUP_WORDS;
      cand_s = base_s + 32'(grp_pe.index);
      stat.scan_hit = (base_s < 32'(nw_s)) && grp_pe.found && (cand_s < 32'(nw_s));
      stat.scan_full = !stat.scan_hit
         && ((base_s >= 32'(nw_s)) || grp_pe.found || (group_ff == GW'(GROUPS - 1)));
      stat.clear_last = (clr_ff == AW'(WORDS - 1));
      stat.range_bad = (idx_ff == '0) || (idx_ff > size_s);
   end

   always_comb begin
      bit0_s = idx_ff - 1'b1;
      free_word_s = AW'(32'(bit0_s) / WORD_BITS);
      ram_raddr = cmd.free_read ? free_word_s : AW'(cand_s);
   end

   // in-range clear bits of the word just read
   always_comb begin
      lim_s = 32'(size_s) - 32'(word_ff) * WORD_BITS;
      for (int b = 0; b < WORD_BITS; b++) begin
         mask_s[b] = 32'(b) < lim_s;
      end
      alloc_pe = lowest_set(~ram_rdata & mask_s);
      set_word = ram_rdata | (WORD_BITS'(1) << alloc_pe.index);
      clr_word = ram_rdata & ~(WORD_BITS'(1) << bitpos_ff);
   end

   always_comb begin
      cmd_in = cmd_ff;
      idx_in = idx_ff;
      group_in = group_ff;
      word_in = word_ff;
      bitpos_in = bitpos_ff;
      free_in = free_ff;
      full_in = full_ff;
      clr_in = clr_ff;
      rsp_in = rsp_ff;
      strobe_in = 1'b0;
      ram_we = 1'b0;
      ram_waddr = word_ff;
      ram_wdata = set_word;

      if (cmd.load) begin
         cmd_in = req_data.command;
         idx_in = req_data.entry_index;
         group_in = '0;
      end
      if (cmd.clear_step) begin
         ram_we = 1'b1;
         ram_waddr = clr_ff;
         ram_wdata = '0;
         clr_in = clr_ff + 1'b1;
      end
      if (cmd.scan_step) begin
         group_in = group_ff + 1'b1;
         word_in = AW'(cand_s);
      end
      if (cmd.free_read) begin
         word_in = free_word_s;
         bitpos_in = bit0_s[BIT_W-1:0];
      end
      if (cmd.resp_full) begin
         strobe_in = 1'b1;
         rsp_in.granted_index = '0;
         rsp_in.status = STATUS_FULL;
         rsp_in.free_count = free_ff;
      end
      if (cmd.resp_range) begin
         strobe_in = 1'b1;
         rsp_in.granted_index = '0;
         rsp_in.status = STATUS_RANGE;
         rsp_in.free_count = free_ff;
      end
      if (cmd.update) begin
         strobe_in = 1'b1;
         rsp_in.granted_index = '0;
         rsp_in.status = STATUS_OK;
         if (cmd_ff == CMD_FREE) begin
            ram_we = 1'b1;
            ram_wdata = clr_word;
            full_in[word_ff] = 1'b0;
            free_in = (free_ff < size_s) ? free_ff + 1'b1 : size_s;
         end else if (alloc_pe.found) begin
            ram_we = 1'b1;
            ram_wdata = set_word;
            full_in[word_ff] = &set_word;
            free_in = (free_ff != '0) ? free_ff - 1'b1 : free_ff;
            rsp_in.granted_index =
               SIZE_W'(32'(word_ff) * WORD_BITS + 32'(alloc_pe.index) + 32'd1);
         end else begin
            rsp_in.status = STATUS_FULL;
         end
         rsp_in.free_count = free_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_ff <= SIZE_W'(RESET_SIZE);
         full_ff <= '0;
         clr_ff <= '0;
         strobe_ff <= 1'b0;
      end else begin
         free_ff <= free_in;
         full_ff <= full_in;
         clr_ff <= clr_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      idx_ff <= idx_in;
      group_ff <= group_in;
      word_ff <= word_in;
      bitpos_ff <= bitpos_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_data = rsp_ff;
   assign rsp_strobe = strobe_ff;

endmodule

// ===== src/bitmap_slot_allocator.sv =====
// First-fit slot allocator over an allocation bitmap held in a 64-bit-wide RAM, with a
// flip-flop summary of full words. An item is taken when start is high and busy is low.
// Allocate scans the summary 32 words a cycle over at most ceil(MAP_BITS / 2048) groups,
// four for 8192 entries, then reads the word found and sets its lowest in-range clear
// bit; it ends after the scan when the summary already shows every word in range full.
// Free reads the indexed word and clears the bit; a free with a bad index ends after the
// read. The result shows on rsp_data in the cycle after the work ends, for a single cycle
// with rsp_strobe high; the receiver cannot stall it, and the next transaction can be
// taken in that same cycle. After reset the block clears the ceil(MAP_BITS / 64) bitmap
// RAM words one word a cycle, with busy high; map_size writes are taken throughout.
module bitmap_slot_allocator #(
   parameter int MAP_BITS = bsa_pkg::MAP_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  bsa_pkg::req_type                  req_data,
   output logic                              rsp_strobe,
   output bsa_pkg::rsp_type                  rsp_data,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [bsa_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [bsa_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [bsa_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                              pready
);
   import bsa_pkg::*;

   logic [SIZE_W-1:0] map_size_ff, map_size_in;
   logic              csr_write;
   logic              csr_hit;
   ctrl_cmd_type      cmd;
   ctrl_status_type   stat;

   always_comb begin
      csr_hit = (paddr[CSR_ADDR_W-1:2] == REG_MAP_SIZE);
      csr_write = psel && penable && pwrite && pready;
      map_size_in = (csr_write && csr_hit) ? pwdata[SIZE_W-1:0] : map_size_ff;
      prdata = csr_hit ? CSR_DATA_W'(map_size_ff) : '0;
   end

   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         map_size_ff <= SIZE_W'(MAP_SIZE_RESET);
      end else begin
         map_size_ff <= map_size_in;
      end
   end

   bsa_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .start(start),
      .req_command(req_data.command),
      .stat(stat),
      .cmd(cmd),
      .busy(busy)
   );

   bsa_datapath #(
      .MAP_BITS(MAP_BITS)
   ) u_datapath (
      .clock(clock),
      .reset(reset),
      .req_data(req_data),
      .map_size(map_size_ff),
      .cmd(cmd),
      .stat(stat),
      .rsp_data(rsp_data),
      .rsp_strobe(rsp_strobe)
   );

`ifndef SYNTH
   a_no_strobe_after_accept: assert property (
      @(posedge clock) disable iff (reset)
      (start && !busy) |=> !rsp_strobe
   ) else $error("result strobe right after a transaction was taken");

   a_grant_only_ok: assert property (
      @(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.granted_index != '0) |-> (rsp_data.status == STATUS_OK)
   ) else $error("nonzero granted index with error status");

   a_busy_while_clearing: assert property (
      @(posedge clock) disable iff (reset)
      $fell(reset) |-> busy
   ) else $error("block idle before bitmap clear finished");
`endif

endmodule
